### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/asl_pkg.sv
// types and constants of the address to symbol lookup
package asl_pkg;

	localparam logic [2:0] OP_LOAD_ADDR   = 3'd0;
	localparam logic [2:0] OP_LOAD_NAME   = 3'd1;
	localparam logic [2:0] OP_LOAD_MARKER = 3'd2;
	localparam logic [2:0] OP_LOAD_TOKEN  = 3'd3;
	localparam logic [2:0] OP_LOAD_TIDX   = 3'd4;
	localparam logic [2:0] OP_LOOKUP      = 3'd5;

	localparam logic [2:0] REG_SYMBOL_COUNT = 3'd0;
	localparam logic [2:0] REG_TEXT_START   = 3'd1;
	localparam logic [2:0] REG_TEXT_END     = 3'd2;
	localparam logic [2:0] REG_INIT_START   = 3'd3;
	localparam logic [2:0] REG_INIT_END     = 3'd4;

	localparam int CHUNK_CHARS = 8;
	localparam int MARKER_SPAN = 256;
	localparam int TOKEN_COUNT = 256;

	typedef enum logic [22:0] {
		ST_IDLE    = 23'h000001,
		ST_BS_RD   = 23'h000002,
		ST_BS_CMP  = 23'h000004,
		ST_MRK_RD  = 23'h000008,
		ST_MRK_WT  = 23'h000010,
		ST_SK_RD   = 23'h000020,
		ST_SK_WT   = 23'h000040,
		ST_END_RD  = 23'h000080,
		ST_END_WT  = 23'h000100,
		ST_CUR_RD  = 23'h000200,
		ST_CUR_WT  = 23'h000400,
		ST_AL_RD   = 23'h000800,
		ST_AL_WT   = 23'h001000,
		ST_LEN_RD  = 23'h002000,
		ST_LEN_WT  = 23'h004000,
		ST_CODE_RD = 23'h008000,
		ST_CODE_WT = 23'h010000,
		ST_IDX_WT  = 23'h020000,
		ST_TOK_RD  = 23'h040000,
		ST_TOK_WT  = 23'h080000,
		ST_NX_RD   = 23'h100000,
		ST_NX_WT   = 23'h200000,
		ST_EMIT    = 23'h400000
	} state_t;

endpackage

### rtl/address_to_symbol_lookup_top.sv
// address to symbol lookup over a token compressed symbol table
// one item at a time: a load item writes one table entry; a lookup checks the text and
// init ranges and, on a hit, binary-searches the address table, walks the name stream
// from the marker of its group (up to 255 skipped entries, done once and again after the
// alias walk), steps back over aliases, expands the name, scans forward for the next
// higher address or the section end and then emits one to sixteen result items, one per
// cycle while not stalled; a miss emits a single all-zero item; each table memory has a
// single read port; no clearing pass, the tables hold garbage until loaded
`include "assert_macros.svh"

module address_to_symbol_lookup_top #(
	parameter int MAX_SYMBOLS       = 16384,
	parameter int NAME_STREAM_BYTES = 65536,
	parameter int TOKEN_BYTES       = 4096,
	parameter int NAME_LEN          = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] slot,
	input  logic [63:0] load_value,
	input  logic [63:0] query_address,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [63:0] symbol_size,
	output logic [63:0] symbol_offset,
	output logic [63:0] name_chunk,
	output logic        last_chunk
);

	// widths derived from the table sizes
	localparam int AW  = $clog2(MAX_SYMBOLS);
	localparam int NW  = AW + 1;
	localparam int SW  = $clog2(NAME_STREAM_BYTES);
	localparam int PW  = ((SW > 16) ? SW : 16) + 2;
	localparam int TBW = $clog2(TOKEN_BYTES);
	localparam int TW  = ((TBW > 12) ? TBW : 12) + 1;
	localparam int MC  = MAX_SYMBOLS / asl_pkg::MARKER_SPAN;
	localparam int MW  = (MC > 1) ? $clog2(MC) : 1;
	localparam int NLW = $clog2(NAME_LEN + 1);
	localparam int CH  = (NAME_LEN + asl_pkg::CHUNK_CHARS - 1) / asl_pkg::CHUNK_CHARS;
	localparam int CW  = (CH > 1) ? $clog2(CH) : 1;
	localparam int CNW = $clog2(CH + 1);

	// configuration registers
	logic [14:0] sym_count_q;
	logic [63:0] text_start_q, text_end_q, init_start_q, init_end_q;

	// table memories, one write and one registered read port each
	logic [63:0] addr_mem [MAX_SYMBOLS];
	logic [7:0]  name_mem [NAME_STREAM_BYTES];
	logic [15:0] mrk_mem  [MC];
	logic [7:0]  tok_mem  [TOKEN_BYTES];
	logic [11:0] tidx_mem [asl_pkg::TOKEN_COUNT];

	logic [63:0] addr_rd_q;
	logic [7:0]  name_rd_q;
	logic        name_oob_q;
	logic [15:0] mrk_rd_q;
	logic [7:0]  tok_rd_q;
	logic        tok_oob_q;
	logic [11:0] tidx_rd_q;

	// sequencer state
	asl_pkg::state_t state_q;
	logic [63:0] qaddr_q, cur_q, end_q, size_q, off_q;
	logic        in_init_q, have_end_q, found_q, pass_q, first_q;
	logic [NW-1:0] low_q, high_q, idx_q;
	logic [PW-1:0] pos_q;
	logic [7:0]  skip_q, len_q;
	logic [8:0]  k_q;
	logic [TW-1:0] t_q;
	logic [NLW-1:0] nlen_q;
	logic [CW-1:0] kc_q;
	logic [63:0] chunk_q [CH];

	logic accept, lookup_acc, in_text_w, in_init_w, cfg_wr;
	logic [NW-1:0] n_w, mid_w;
	logic [NW:0]   sum_w;
	logic [AW-1:0] addr_ra;
	logic [PW-1:0] name_pos;
	logic [7:0]  name_b, tok_c;
	logic [CNW-1:0] chunks_w;
	logic [CW-1:0] ci_w;
	logic [2:0]  lane_w;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q  <= '0;
			text_start_q <= '0;
			text_end_q   <= '0;
			init_start_q <= '0;
			init_end_q   <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				asl_pkg::REG_SYMBOL_COUNT: sym_count_q  <= pwdata[14:0];
				asl_pkg::REG_TEXT_START:   text_start_q <= pwdata;
				asl_pkg::REG_TEXT_END:     text_end_q   <= pwdata;
				asl_pkg::REG_INIT_START:   init_start_q <= pwdata;
				asl_pkg::REG_INIT_END:     init_end_q   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			asl_pkg::REG_SYMBOL_COUNT: prdata = {49'd0, sym_count_q};
			asl_pkg::REG_TEXT_START:   prdata = text_start_q;
			asl_pkg::REG_TEXT_END:     prdata = text_end_q;
			asl_pkg::REG_INIT_START:   prdata = init_start_q;
			asl_pkg::REG_INIT_END:     prdata = init_end_q;
			default:                   prdata = '0;
		endcase
	end

	// one item at a time
	assign in_stall   = (state_q != asl_pkg::ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign lookup_acc = accept && (opcode == asl_pkg::OP_LOOKUP);

	assign in_text_w = (query_address >= text_start_q) && (query_address < text_end_q);
	assign in_init_w = (query_address >= init_start_q) && (query_address < init_end_q);

	// symbol count saturated to the table depth
	assign n_w = ({17'd0, sym_count_q} > 32'(MAX_SYMBOLS)) ? NW'(MAX_SYMBOLS)
		: NW'(sym_count_q);
	assign sum_w = {1'b0, low_q} + {1'b0, high_q};
	assign mid_w = NW'(sum_w >> 1);

	// address table read index per state
	always_comb begin
		unique case (state_q)
			asl_pkg::ST_BS_RD: addr_ra = AW'(mid_w);
			asl_pkg::ST_AL_RD: addr_ra = AW'(low_q - NW'(1));
			asl_pkg::ST_NX_RD: addr_ra = AW'(idx_q);
			default:           addr_ra = AW'(low_q);
		endcase
	end

	assign name_pos = (state_q == asl_pkg::ST_CODE_RD) ? PW'(pos_q + PW'(k_q)) : pos_q;
	// reads past the stream or token pool give zero
	assign name_b   = name_oob_q ? 8'd0 : name_rd_q;
	assign tok_c    = tok_oob_q ? 8'd0 : tok_rd_q;

	always_ff @(posedge clk) begin
		if (accept && opcode == asl_pkg::OP_LOAD_ADDR && {16'd0, slot} < 32'(MAX_SYMBOLS))
			addr_mem[AW'(slot)] <= load_value;
		addr_rd_q <= addr_mem[addr_ra];
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == asl_pkg::OP_LOAD_NAME
			&& {16'd0, slot} < 32'(NAME_STREAM_BYTES))
			name_mem[SW'(slot)] <= load_value[7:0];
		name_rd_q  <= name_mem[SW'(name_pos)];
		name_oob_q <= (32'(name_pos) >= 32'(NAME_STREAM_BYTES));
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == asl_pkg::OP_LOAD_MARKER && {16'd0, slot} < 32'(MC))
			mrk_mem[MW'(slot)] <= load_value[15:0];
		mrk_rd_q <= mrk_mem[MW'(low_q >> 8)];
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == asl_pkg::OP_LOAD_TOKEN && {16'd0, slot} < 32'(TOKEN_BYTES))
			tok_mem[TBW'(slot)] <= load_value[7:0];
		tok_rd_q  <= tok_mem[TBW'(t_q)];
		tok_oob_q <= (32'(t_q) >= 32'(TOKEN_BYTES));
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == asl_pkg::OP_LOAD_TIDX
			&& {16'd0, slot} < 32'(asl_pkg::TOKEN_COUNT))
			tidx_mem[slot[7:0]] <= load_value[11:0];
		tidx_rd_q <= tidx_mem[name_b];
	end

	// name buffer, filled one character at a time
	assign ci_w   = CW'(nlen_q >> 3);
	assign lane_w = nlen_q[2:0];

	always_ff @(posedge clk) begin
		for (int j = 0; j < CH; j++) begin
			if (state_q == asl_pkg::ST_TOK_WT && tok_c != 8'd0 && 32'(nlen_q) < 32'(NAME_LEN)
				&& !first_q && ci_w == CW'(j)) begin
				if (lane_w == 3'd0)
					chunk_q[j] <= {56'd0, tok_c};
				else
					chunk_q[j][8*lane_w +: 8] <= tok_c;
			end
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asl_pkg::ST_IDLE;
			kc_q    <= '0;
		end else begin
			unique case (state_q)
				asl_pkg::ST_IDLE: begin
					if (lookup_acc) begin
						qaddr_q    <= query_address;
						in_init_q  <= in_init_w;
						have_end_q <= 1'b0;
						pass_q     <= 1'b0;
						nlen_q     <= '0;
						kc_q       <= '0;
						low_q      <= '0;
						high_q     <= n_w;
						if (in_text_w || in_init_w) begin
							found_q <= 1'b1;
							state_q <= asl_pkg::ST_BS_RD;
						end else begin
							// miss: a single all-zero result
							found_q <= 1'b0;
							size_q  <= '0;
							off_q   <= '0;
							state_q <= asl_pkg::ST_EMIT;
						end
					end
				end
				asl_pkg::ST_BS_RD: begin
					if ({1'b0, high_q} > {1'b0, low_q} + (NW+1)'(1))
						state_q <= asl_pkg::ST_BS_CMP;
					else
						state_q <= asl_pkg::ST_MRK_RD;
				end
				asl_pkg::ST_BS_CMP: begin
					if (addr_rd_q <= qaddr_q)
						low_q <= mid_w;
					else
						high_q <= mid_w;
					state_q <= asl_pkg::ST_BS_RD;
				end
				// entry offset: marker of the group, then skip entries
				asl_pkg::ST_MRK_RD: state_q <= asl_pkg::ST_MRK_WT;
				asl_pkg::ST_MRK_WT: begin
					pos_q   <= PW'(mrk_rd_q);
					skip_q  <= '0;
					state_q <= asl_pkg::ST_SK_RD;
				end
				asl_pkg::ST_SK_RD: begin
					if (skip_q == low_q[7:0])
						state_q <= pass_q ? asl_pkg::ST_LEN_RD : asl_pkg::ST_END_RD;
					else
						state_q <= asl_pkg::ST_SK_WT;
				end
				asl_pkg::ST_SK_WT: begin
					pos_q   <= pos_q + PW'(name_b) + PW'(1);
					skip_q  <= skip_q + 8'd1;
					state_q <= asl_pkg::ST_SK_RD;
				end
				// an empty name marks an end entry
				asl_pkg::ST_END_RD: state_q <= asl_pkg::ST_END_WT;
				asl_pkg::ST_END_WT: begin
					if (name_b == 8'd0 && low_q != '0) begin
						end_q      <= addr_rd_q;
						have_end_q <= 1'b1;
						low_q      <= low_q - NW'(1);
					end
					state_q <= asl_pkg::ST_CUR_RD;
				end
				asl_pkg::ST_CUR_RD: state_q <= asl_pkg::ST_CUR_WT;
				asl_pkg::ST_CUR_WT: begin
					cur_q   <= addr_rd_q;
					state_q <= asl_pkg::ST_AL_RD;
				end
				// back to the first alias
				asl_pkg::ST_AL_RD: begin
					if (low_q != '0) begin
						state_q <= asl_pkg::ST_AL_WT;
					end else begin
						pass_q  <= 1'b1;
						state_q <= asl_pkg::ST_MRK_RD;
					end
				end
				asl_pkg::ST_AL_WT: begin
					if (addr_rd_q == cur_q) begin
						low_q   <= low_q - NW'(1);
						state_q <= asl_pkg::ST_AL_RD;
					end else begin
						pass_q  <= 1'b1;
						state_q <= asl_pkg::ST_MRK_RD;
					end
				end
				// name expansion
				asl_pkg::ST_LEN_RD: state_q <= asl_pkg::ST_LEN_WT;
				asl_pkg::ST_LEN_WT: begin
					len_q   <= name_b;
					k_q     <= 9'd1;
					first_q <= 1'b1;
					state_q <= asl_pkg::ST_CODE_RD;
				end
				asl_pkg::ST_CODE_RD: begin
					if (k_q <= {1'b0, len_q} && 32'(nlen_q) < 32'(NAME_LEN)) begin
						state_q <= asl_pkg::ST_CODE_WT;
					end else begin
						idx_q   <= low_q + NW'(1);
						state_q <= asl_pkg::ST_NX_RD;
					end
				end
				asl_pkg::ST_CODE_WT: state_q <= asl_pkg::ST_IDX_WT;
				asl_pkg::ST_IDX_WT: begin
					t_q     <= TW'(tidx_rd_q);
					state_q <= asl_pkg::ST_TOK_RD;
				end
				asl_pkg::ST_TOK_RD: state_q <= asl_pkg::ST_TOK_WT;
				asl_pkg::ST_TOK_WT: begin
					if (tok_c != 8'd0 && 32'(nlen_q) < 32'(NAME_LEN)) begin
						// the type character is dropped
						if (first_q)
							first_q <= 1'b0;
						else
							nlen_q <= nlen_q + NLW'(1);
						t_q     <= t_q + TW'(1);
						state_q <= asl_pkg::ST_TOK_RD;
					end else begin
						k_q     <= k_q + 9'd1;
						state_q <= asl_pkg::ST_CODE_RD;
					end
				end
				// symbol end: next higher address or section end
				asl_pkg::ST_NX_RD: begin
					if (have_end_q) begin
						size_q  <= end_q - cur_q;
						off_q   <= qaddr_q - cur_q;
						state_q <= asl_pkg::ST_EMIT;
					end else if (idx_q < n_w) begin
						state_q <= asl_pkg::ST_NX_WT;
					end else begin
						end_q      <= in_init_q ? init_end_q : text_end_q;
						have_end_q <= 1'b1;
					end
				end
				asl_pkg::ST_NX_WT: begin
					if (addr_rd_q > cur_q) begin
						end_q      <= addr_rd_q;
						have_end_q <= 1'b1;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
					state_q <= asl_pkg::ST_NX_RD;
				end
				asl_pkg::ST_EMIT: begin
					if (!out_stall) begin
						if (last_chunk)
							state_q <= asl_pkg::ST_IDLE;
						else
							kc_q <= kc_q + CW'(1);
					end
				end
				default: state_q <= asl_pkg::ST_IDLE;
			endcase
		end
	end

	// result item, straight from registers
	assign chunks_w = (nlen_q == '0) ? CNW'(1)
		: CNW'(({1'b0, nlen_q} + (NLW+1)'(7)) >> 3);
	assign out_valid     = (state_q == asl_pkg::ST_EMIT);
	assign found         = found_q;
	assign symbol_size   = size_q;
	assign symbol_offset = off_q;
	assign name_chunk    = (nlen_q == '0) ? 64'd0 : chunk_q[kc_q];
	assign last_chunk    = ((CNW'(kc_q) + CNW'(1)) == chunks_w);

	`ASL_ASSERT(a_bs_order, clk, arst_n, ((state_q != asl_pkg::ST_BS_RD && state_q != asl_pkg::ST_BS_CMP) || low_q <= high_q), "binary search bounds crossed")
	`ASL_ASSERT(a_name_len, clk, arst_n, (32'(nlen_q) <= 32'(NAME_LEN)), "name longer than limit")
	`ASL_ASSERT(a_emit_idx, clk, arst_n, (state_q != asl_pkg::ST_EMIT || CNW'(kc_q) < chunks_w), "chunk index past name")
	`ASL_ASSERT_NEXT(a_lookup_go, clk, arst_n, lookup_acc, state_q != asl_pkg::ST_IDLE, "lookup not started")

endmodule
